// ===== sv/pair_key_lru_cache_directory_assert.svh =====
// Assertion macros for the pair-keyed LRU directory.
// Used by the port checker; no other dependencies.
`ifndef PAIR_KEY_LRU_CACHE_DIRECTORY_ASSERT_SVH
`define PAIR_KEY_LRU_CACHE_DIRECTORY_ASSERT_SVH

// Property checked only while out of reset.
`define PKLRU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Property checked on every edge, reset included.
`define PKLRU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== sv/pklru_pkg.sv =====
// Shared types and constants for the pair-keyed LRU directory.
// No dependencies.
`timescale 1ns / 1ps

package pklru_pkg;

    localparam int KEY_W    = 20;
    localparam int STAMP_W  = 64;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 7;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FILL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EVICT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FAIL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FLUSH = 3'd4;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key_from;
        logic [KEY_W-1:0] key_to;
        logic             build_ok;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
    } out_item_t;

endpackage

// ===== sv/pklru_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module pklru_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

// ===== sv/pair_key_lru_cache_directory.sv =====
// Pair-keyed LRU directory. A flush goes straight to the result; a lookup reads the filled
// slots in order and stops at the first hit, while a miss reads every filled slot;
// the key and stamp RAMs are read one entry per cycle, so the fill count sets the scan.
// Only one item is in flight; the next transfer is taken in the cycle after the result is
// committed to the output register, and a result held by m_ready keeps s_ready low.
// Synchronous active-low reset empties the directory and zeroes the use clock; RAMs keep data.
`timescale 1ns / 1ps

module pair_key_lru_cache_directory #(
    parameter int ENTRIES = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pklru_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pklru_pkg::out_item_t m_item
);

    localparam int IW = $clog2(ENTRIES);      // slot address bits
    localparam int CW = $clog2(ENTRIES + 1);  // fill count / scan counter bits
    localparam int KW = 2 * pklru_pkg::KEY_W;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        RESP
    } state_t;

    state_t                              state_reg, state_next;
    pklru_pkg::in_item_t                 req_reg, req_next;
    logic [CW-1:0]                       addr_reg, addr_next;
    logic                                pend_reg, pend_next;
    logic [IW-1:0]                       pend_idx_reg, pend_idx_next;
    logic [pklru_pkg::STAMP_W-1:0]       min_stamp_reg, min_stamp_next;
    logic [IW-1:0]                       min_idx_reg, min_idx_next;
    logic [pklru_pkg::STATUS_W-1:0]      res_status_reg, res_status_next;
    logic [IW-1:0]                       res_slot_reg, res_slot_next;
    logic [CW-1:0]                       fill_reg, fill_next;
    logic [pklru_pkg::STAMP_W-1:0]       clock_reg, clock_next;
    logic                                m_valid_reg, m_valid_next;
    pklru_pkg::out_item_t                m_item_reg, m_item_next;

    logic                                issue;
    logic                                commit;
    logic                                key_hit;
    logic [KW-1:0]                       key_rdata;
    logic [pklru_pkg::STAMP_W-1:0]       stamp_rdata;
    logic                                key_we;
    logic                                stamp_we;
    logic [pklru_pkg::STAMP_W-1:0]       clock_inc;
    logic [IW+pklru_pkg::SLOT_W-1:0]     slot_wide;

    // Key store: {key_from, key_to} per slot.
    pklru_ram #(
        .WIDTH(KW),
        .DEPTH(ENTRIES)
    ) u_key_ram (
        .aclk     (aclk),
        .we       (key_we),
        .waddr    (res_slot_reg),
        .wdata    ({req_reg.key_from, req_reg.key_to}),
        .raddr    (addr_reg[IW-1:0]),
        .rdata_reg(key_rdata)
    );

    // Use stamp per slot, read alongside the key during the scan.
    pklru_ram #(
        .WIDTH(pklru_pkg::STAMP_W),
        .DEPTH(ENTRIES)
    ) u_stamp_ram (
        .aclk     (aclk),
        .we       (stamp_we),
        .waddr    (res_slot_reg),
        .wdata    (clock_inc),
        .raddr    (addr_reg[IW-1:0]),
        .rdata_reg(stamp_rdata)
    );

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // A read goes out every scan cycle while the address is below the fill count;
    // its registered data comes back in the next cycle, tagged by pend_reg / pend_idx_reg.
    assign issue   = (state_reg == SCAN) && (addr_reg < fill_reg);
    assign key_hit = pend_reg && (key_rdata == {req_reg.key_from, req_reg.key_to});

    // Commit the result once the output register is free; all RAM writes and
    // counter updates land on this same edge, so the next scan sees them.
    assign commit    = (state_reg == RESP) && (!m_valid_reg || m_ready);
    assign clock_inc = clock_reg + pklru_pkg::STAMP_W'(1);
    assign key_we    = commit && ((res_status_reg == pklru_pkg::ST_FILL) ||
                                  (res_status_reg == pklru_pkg::ST_EVICT));
    assign stamp_we  = commit && ((res_status_reg == pklru_pkg::ST_HIT) ||
                                  (res_status_reg == pklru_pkg::ST_FILL) ||
                                  (res_status_reg == pklru_pkg::ST_EVICT));

    // Report only the low slot bits; zero-extend when the directory is small.
    assign slot_wide = {{pklru_pkg::SLOT_W{1'b0}}, res_slot_reg};

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        pend_next       = issue;
        pend_idx_next   = addr_reg[IW-1:0];
        min_stamp_next  = min_stamp_reg;
        min_idx_next    = min_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        fill_next       = fill_reg;
        clock_next      = clock_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;

        if (issue) begin
            addr_next = addr_reg + CW'(1);
        end

        unique case (state_reg)
            IDLE: begin
                pend_next = 1'b0;
                addr_next = '0;
                if (s_valid) begin
                    req_next = s_item;
                    if (s_item.opcode == pklru_pkg::OP_FLUSH) begin
                        res_status_next = pklru_pkg::ST_FLUSH;
                        res_slot_next   = '0;
                        state_next      = RESP;
                    end else begin
                        state_next = SCAN;
                    end
                end
            end
            SCAN: begin
                if (key_hit) begin
                    // Stop the scan at the first matching slot.
                    res_status_next = pklru_pkg::ST_HIT;
                    res_slot_next   = pend_idx_reg;
                    state_next      = RESP;
                end else if (pend_reg) begin
                    // Track the oldest stamp; strict compare keeps the lowest index on ties.
                    if ((pend_idx_reg == '0) || (stamp_rdata < min_stamp_reg)) begin
                        min_stamp_next = stamp_rdata;
                        min_idx_next   = pend_idx_reg;
                    end
                end else if (!issue) begin
                    // Scan drained with no match: decide the miss.
                    state_next = RESP;
                    if (!req_reg.build_ok) begin
                        res_status_next = pklru_pkg::ST_FAIL;
                        res_slot_next   = '0;
                    end else if (fill_reg < CW'(ENTRIES)) begin
                        res_status_next = pklru_pkg::ST_FILL;
                        res_slot_next   = fill_reg[IW-1:0];
                    end else begin
                        res_status_next = pklru_pkg::ST_EVICT;
                        res_slot_next   = min_idx_reg;
                    end
                end
            end
            RESP: begin
                if (commit) begin
                    m_valid_next           = 1'b1;
                    m_item_next.status     = res_status_reg;
                    m_item_next.slot_index = slot_wide[pklru_pkg::SLOT_W-1:0];
                    if (res_status_reg == pklru_pkg::ST_FLUSH) begin
                        fill_next  = '0;
                        clock_next = '0;
                    end else if (stamp_we) begin
                        clock_next = clock_inc;
                    end
                    if (res_status_reg == pklru_pkg::ST_FILL) begin
                        fill_next = fill_reg + CW'(1);
                    end
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            pend_reg    <= 1'b0;
            fill_reg    <= '0;
            clock_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            fill_reg    <= fill_next;
            clock_reg   <= clock_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        pend_idx_reg   <= pend_idx_next;
        min_stamp_reg  <= min_stamp_next;
        min_idx_reg    <= min_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_item_reg     <= m_item_next;
    end

endmodule

// ===== sv/pklru_checker.sv =====
// Port-level checker for the pair-keyed LRU directory, bound to the top level.
// Depends on pklru_pkg and pair_key_lru_cache_directory_assert.svh.
`timescale 1ns / 1ps
`include "pair_key_lru_cache_directory_assert.svh"

module pklru_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input pklru_pkg::in_item_t  s_item,
    input logic                 m_valid,
    input logic                 m_ready,
    input pklru_pkg::out_item_t m_item
);

    logic s_xfer;
    logic status_ok;
    logic no_slot;

    assign s_xfer    = s_valid && s_ready;
    assign status_ok = (m_item.status <= pklru_pkg::ST_FLUSH);
    // Failed builds and flushes carry no slot.
    assign no_slot   = (m_item.status == pklru_pkg::ST_FAIL) ||
                       (m_item.status == pklru_pkg::ST_FLUSH);

    `PKLRU_ASSERT(a_m_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "result dropped")
    `PKLRU_ASSERT_ALWAYS(a_rst_out, aclk, (!aresetn) |=> !m_valid, "result valid after reset")
    `PKLRU_ASSERT(a_one_item, aclk, aresetn, s_xfer |=> !s_ready, "second item taken mid-work")
    `PKLRU_ASSERT(a_status, aclk, aresetn, m_valid |-> status_ok, "bad status")
    `PKLRU_ASSERT(a_slot_zero, aclk, aresetn, (m_valid && no_slot) |-> (m_item.slot_index == '0), "slot not zero")

endmodule

bind pair_key_lru_cache_directory pklru_checker u_pklru_checker (.*);

// ===== tb/sv/pair_key_lru_cache_directory_tb.sv =====
// Self-checking testbench for pair_key_lru_cache_directory: directed and random lookups and
// flushes, checked against a predicted copy of the directory held in a scoreboard class.
// Depends on pklru_pkg and the block itself.
`timescale 1ns / 1ps

module pair_key_lru_cache_directory_tb;

    localparam int KEY_W          = pklru_pkg::KEY_W;
    localparam int STAMP_W        = pklru_pkg::STAMP_W;
    localparam int SLOT_W         = pklru_pkg::SLOT_W;
    localparam int DIR_ENTRIES    = 128;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int POOL_PAIRS     = 180;
    localparam int NARROW_PAIRS   = 24;
    localparam int HOLD_OFF       = 300;
    localparam int HOLD_AT_RESULT = 500;
    localparam int PAUSE_AT_ITEM  = 625;
    localparam int KEY_MAX        = 999999;
    // Worst lookup: one scan over a full directory that finds the key and the LRU slot together.
    localparam int DRAIN_CYCLES   = 2 * DIR_ENTRIES + 16;
    localparam int QUIET_LIMIT    = 4 * (HOLD_OFF + DRAIN_CYCLES + 16);

    // Predicted directory contents and the queue of responses still owed by the block.
    class directory_scoreboard;
        pklru_pkg::out_item_t   pending_rsp[$];
        int unsigned            fail_count;
        logic [KEY_W-1:0]       tag_from [DIR_ENTRIES];
        logic [KEY_W-1:0]       tag_to   [DIR_ENTRIES];
        logic [STAMP_W-1:0]     last_use [DIR_ENTRIES];
        int unsigned            used_slots;
        logic [STAMP_W-1:0]     use_clock = '0;

        // Filled entry with the smallest stamp; strict compare keeps the lowest index on ties.
        function int unsigned oldest_slot();
            int unsigned        best;
            logic [STAMP_W-1:0] best_stamp;
            best       = 0;
            best_stamp = last_use[0];
            for (int unsigned i = 1; i < used_slots; i++) begin
                if (last_use[i] < best_stamp) begin
                    best_stamp = last_use[i];
                    best       = i;
                end
            end
            return best;
        endfunction

        function pklru_pkg::out_item_t predict_response(pklru_pkg::in_item_t req);
            pklru_pkg::out_item_t rsp;
            int unsigned          slot;
            rsp = '0;
            if (req.opcode == pklru_pkg::OP_FLUSH) begin
                used_slots = 0;
                use_clock  = '0;
                rsp.status = pklru_pkg::ST_FLUSH;
                return rsp;
            end
            for (int unsigned i = 0; i < used_slots; i++) begin
                if (tag_from[i] == req.key_from && tag_to[i] == req.key_to) begin
                    use_clock      = use_clock + 1'b1;
                    last_use[i]    = use_clock;
                    rsp.status     = pklru_pkg::ST_HIT;
                    rsp.slot_index = SLOT_W'(i);
                    return rsp;
                end
            end
            // A failed build leaves the directory and the clock untouched.
            if (!req.build_ok) begin
                rsp.status = pklru_pkg::ST_FAIL;
                return rsp;
            end
            if (used_slots < DIR_ENTRIES) begin
                slot       = used_slots;
                used_slots = used_slots + 1;
                rsp.status = pklru_pkg::ST_FILL;
            end else begin
                slot       = oldest_slot();
                rsp.status = pklru_pkg::ST_EVICT;
            end
            tag_from[slot] = req.key_from;
            tag_to[slot]   = req.key_to;
            use_clock      = use_clock + 1'b1;
            last_use[slot] = use_clock;
            rsp.slot_index = SLOT_W'(slot);
            return rsp;
        endfunction

        function void note_request(pklru_pkg::in_item_t req);
            pending_rsp.push_back(predict_response(req));
        endfunction

        function int unsigned outstanding();
            return pending_rsp.size();
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH @%0t: %s", $time, what);
            fail_count++;
        endtask

        task check_response(pklru_pkg::out_item_t got);
            pklru_pkg::out_item_t want;
            if (pending_rsp.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d slot=%0d",
                                          got.status, got.slot_index));
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d",
                                          got.status, want.status));
            if (got.slot_index !== want.slot_index)
                report_mismatch($sformatf("slot_index got %0d want %0d (status %0d)",
                                          got.slot_index, want.slot_index, want.status));
        endtask
    endclass

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    pklru_pkg::in_item_t  s_item  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    pklru_pkg::out_item_t m_item;

    directory_scoreboard sb = new;

    logic [KEY_W-1:0] pool_from [POOL_PAIRS];
    logic [KEY_W-1:0] pool_to   [POOL_PAIRS];
    int unsigned      calm_tx;
    int unsigned      calm_rx;
    int unsigned      quiet_cycles;

    pair_key_lru_cache_directory #(
        .ENTRIES (DIR_ENTRIES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Sample both channels at the edge; note the request first so that a result and the next
    // transfer in the same cycle still line up in order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_request(s_item);
            if (m_valid && m_ready)
                sb.check_response(m_item);
        end
    end

    // Stop the run if neither channel completes a transfer for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic pklru_pkg::in_item_t lookup_req(int unsigned kf, int unsigned kt, bit ok);
        pklru_pkg::in_item_t req;
        req          = '0;
        req.opcode   = pklru_pkg::OP_LOOKUP;
        req.key_from = KEY_W'(kf);
        req.key_to   = KEY_W'(kt);
        req.build_ok = ok;
        return req;
    endfunction

    // Keys and build_ok are don't-care on a flush; fill them with noise.
    function automatic pklru_pkg::in_item_t flush_req();
        pklru_pkg::in_item_t req;
        req = lookup_req($urandom_range(0, KEY_MAX), $urandom_range(0, KEY_MAX),
                         1'($urandom_range(0, 1)));
        req.opcode = pklru_pkg::OP_FLUSH;
        return req;
    endfunction

    // Mostly pairs from a shared pool so hits and evictions occur; some fresh pairs, some crossed
    // pairs that take their source and target keys from two pool pairs, and rare flushes.
    function automatic pklru_pkg::in_item_t random_req(int unsigned pool_lim);
        int unsigned pick;
        int unsigned a;
        int unsigned b;
        bit          ok;
        if ($urandom_range(0, 999) < 5)
            return flush_req();
        pick = $urandom_range(0, 9);
        a    = $urandom_range(0, pool_lim - 1);
        b    = $urandom_range(0, pool_lim - 1);
        ok   = ($urandom_range(0, 9) != 0);
        if (pick < 7)
            return lookup_req(32'(pool_from[a]), 32'(pool_to[a]), ok);
        if (pick == 7)
            return lookup_req($urandom_range(0, KEY_MAX), $urandom_range(0, KEY_MAX), ok);
        return lookup_req(32'(pool_from[a]), 32'(pool_to[b]), ok);
    endfunction

    // Offer one request after a random gap and hold it until the transfer. Valid is only
    // lowered in the gap branch, so it never drops and rises in the same step.
    task automatic send_request(input pklru_pkg::in_item_t req);
        int unsigned gap;
        if (calm_tx > 0) begin
            gap = 0;
            calm_tx--;
        end else begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 39) == 0)
                calm_tx = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Step past the last transfer edge first so the monitor has noted it.
    task automatic wait_drained();
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic run_directed();
        send_request(flush_req());                      // flush of an empty directory
        send_request(lookup_req(0, 0, 1'b0));           // miss on empty, build fails
        send_request(lookup_req(0, 0, 1'b1));           // fill slot 0
        send_request(lookup_req(0, 0, 1'b0));           // hit ignores build_ok
        send_request(lookup_req(KEY_MAX, KEY_MAX, 1'b1));
        send_request(lookup_req(KEY_MAX, 0, 1'b1));     // source matches, target differs
        send_request(lookup_req(0, KEY_MAX, 1'b1));     // target matches, source differs
        send_request(lookup_req('h7FFFF, 'h7FFFF, 1'b1));
        send_request(lookup_req('h80000, 'h80000, 1'b0));
        send_request(lookup_req(KEY_MAX, KEY_MAX, 1'b0));
        send_request(lookup_req(0, 0, 1'b1));
        send_request(flush_req());
        send_request(lookup_req(KEY_MAX, KEY_MAX, 1'b0)); // old pair gone after flush
        send_request(lookup_req(KEY_MAX, KEY_MAX, 1'b1)); // refill from slot 0
        send_request(lookup_req('h7FFFF, 'h80000, 1'b1));
        send_request(lookup_req(KEY_MAX, KEY_MAX, 1'b1));
        send_request(flush_req());
    endtask

    // Receiver: random stall before each result, calm stretches, and one long hold-off while
    // the sender keeps offering.
    initial begin
        int unsigned stall;
        int unsigned rx_count;
        rx_count = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_count == HOLD_AT_RESULT) begin
                stall = HOLD_OFF;
            end else if (calm_rx > 0) begin
                stall = 0;
                calm_rx--;
            end else begin
                stall = $urandom_range(0, 8);
                if ($urandom_range(0, 39) == 0)
                    calm_rx = $urandom_range(10, 40);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            rx_count++;
        end
    end

    initial begin
        int unsigned pool_lim;
        pool_from[0] = '0;
        pool_to[0]   = '0;
        pool_from[1] = KEY_W'(KEY_MAX);
        pool_to[1]   = KEY_W'(KEY_MAX);
        for (int i = 2; i < POOL_PAIRS; i++) begin
            pool_from[i] = KEY_W'($urandom_range(0, KEY_MAX));
            pool_to[i]   = KEY_W'($urandom_range(0, KEY_MAX));
        end
        calm_tx = 0;
        calm_rx = 0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();

        // Alternate wide-pool segments (fills and evictions) with narrow ones (mostly hits).
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pool_lim = ((n / 250) % 2 == 0) ? POOL_PAIRS : NARROW_PAIRS;
            if (n == PAUSE_AT_ITEM) begin
                // Hold the sender until every owed result has come back.
                s_valid <= 1'b0;
                wait_drained();
            end
            send_request(random_req(pool_lim));
        end
        s_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.outstanding() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.outstanding()));

        if (sb.fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
